>>> src/feedback_delay_line_top_macros.svh
// Assertion macros used by the feedback delay line top level
`ifndef FEEDBACK_DELAY_LINE_TOP_MACROS_SVH
`define FEEDBACK_DELAY_LINE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define FDL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FDL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fdl_pkg.sv
// Shared types and constants of the feedback delay line
`default_nettype none
package fdl_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_LENGTH   = 2'd0,
    REG_DELAY    = 2'd1,
    REG_FEEDBACK = 2'd2,
    REG_MIX      = 2'd3
  } fdl_reg_t;

  typedef struct packed {
    logic acc;
    logic bypass;
    logic fwd;
    logic s1_go;
    logic s2_go;
  } fdl_stage_ctl_t;

endpackage
`default_nettype wire

>>> src/fdl_regs.sv
// APB-style configuration register bank of the feedback delay line
`default_nettype none
module fdl_regs
  import fdl_pkg::*;
#(
  parameter int DEPTH          = 4096,
  parameter int GAIN_FRAC_BITS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic [$clog2(DEPTH+1)-1:0] len,
  output logic [$clog2(DEPTH+1)-1:0] dly,
  output logic [GAIN_FRAC_BITS:0]    fb_gain,
  output logic [GAIN_FRAC_BITS:0]    mix_gain,
  output logic                       len_wr
);

  localparam int LW = $clog2(DEPTH+1);
  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam logic [CFG_DATA_W-1:0] LEN_MAX  = CFG_DATA_W'(DEPTH);
  localparam logic [CFG_DATA_W-1:0] GAIN_MAX = CFG_DATA_W'(1) << GAIN_FRAC_BITS;

  logic [LW-1:0] len_r, dly_r;
  logic [GW-1:0] fb_r, mix_r;
  logic [LW-1:0] len_clamp;
  logic [GW-1:0] gain_clamp;
  logic          wr;
  fdl_reg_t      idx;

  assign idx        = fdl_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr         = psel & penable & pwrite;
  assign len_clamp  = (pwdata > LEN_MAX) ? LEN_MAX[LW-1:0] : pwdata[LW-1:0];
  assign gain_clamp = (pwdata > GAIN_MAX) ? GAIN_MAX[GW-1:0] : pwdata[GW-1:0];
  assign len_wr     = wr & (idx == REG_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      dly_r <= '0;
      fb_r  <= '0;
      mix_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_LENGTH:   len_r <= len_clamp;
        REG_DELAY:    dly_r <= len_clamp;
        REG_FEEDBACK: fb_r  <= gain_clamp;
        REG_MIX:      mix_r <= gain_clamp;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LENGTH:   prdata = CFG_DATA_W'(len_r);
      REG_DELAY:    prdata = CFG_DATA_W'(dly_r);
      REG_FEEDBACK: prdata = CFG_DATA_W'(fb_r);
      REG_MIX:      prdata = CFG_DATA_W'(mix_r);
      default:      prdata = '0;
    endcase
  end

  assign len      = len_r;
  assign dly      = dly_r;
  assign fb_gain  = fb_r;
  assign mix_gain = mix_r;

endmodule
`default_nettype wire

>>> src/fdl_mem.sv
// Delay memory with registered read port and post-reset clearing sweep
`default_nettype none
module fdl_mem #(
  parameter int DEPTH       = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic signed [SAMPLE_BITS-1:0]      rd_data,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic signed [SAMPLE_BITS-1:0] wr_data,
  output logic                               busy
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == LAST) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule
`default_nettype wire

>>> src/fdl_mac.sv
// Gain multiply, round and saturate stages of the feedback delay line
`default_nettype none
module fdl_mac
  import fdl_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 15
) (
  input  wire logic                          clk,
  input  wire fdl_stage_ctl_t                ctl,
  input  wire logic [GAIN_FRAC_BITS:0]       fb_gain,
  input  wire logic [GAIN_FRAC_BITS:0]       mix_gain,
  input  wire logic signed [SAMPLE_BITS-1:0] x_in,
  input  wire logic signed [SAMPLE_BITS-1:0] rd_data,
  output logic signed [SAMPLE_BITS-1:0]      wb_data,
  output logic signed [SAMPLE_BITS-1:0]      y_data
);

  localparam int S    = SAMPLE_BITS;
  localparam int F    = GAIN_FRAC_BITS;
  localparam int GW   = F + 1;
  localparam int ACCW = S + F + 2;
  localparam int QW   = ACCW - F;
  localparam logic [GW-1:0]          GAIN_ONE = GW'(1) << F;
  localparam logic signed [ACCW-1:0] RND      = ACCW'(1) << (F - 1);
  localparam logic signed [QW-1:0]   SMAX     = {3'b000, {(S-1){1'b1}}};
  localparam logic signed [QW-1:0]   SMIN     = {3'b111, {(S-1){1'b0}}};

  function automatic logic signed [S-1:0] rsat(input logic signed [ACCW-1:0] a);
    logic signed [ACCW-1:0] b;
    logic signed [QW-1:0]   q;
    b = a + RND;
    q = QW'(b >>> F);
    if (q > SMAX) begin
      rsat = SMAX[S-1:0];
    end else if (q < SMIN) begin
      rsat = SMIN[S-1:0];
    end else begin
      rsat = q[S-1:0];
    end
  endfunction

  logic signed [S-1:0]    x1_r, x2_r, fwd_data_r, y_r;
  logic                   fwd_sel_r, byp1_r, byp2_r;
  logic signed [S-1:0]    d1;
  logic [GW-1:0]          dry_gain;
  logic signed [ACCW-1:0] pf_nxt, pm_nxt, px_nxt;
  logic signed [ACCW-1:0] pf2_r, pm2_r, px2_r;
  logic signed [ACCW-1:0] x2_scaled;
  logic signed [S-1:0]    y_nxt;

  assign d1       = fwd_sel_r ? fwd_data_r : rd_data;
  assign dry_gain = GAIN_ONE - mix_gain;
  assign pf_nxt   = ACCW'($signed({1'b0, fb_gain}) * d1);
  assign pm_nxt   = ACCW'($signed({1'b0, mix_gain}) * d1);
  assign px_nxt   = ACCW'($signed({1'b0, dry_gain}) * x1_r);

  assign x2_scaled = {{2{x2_r[S-1]}}, x2_r, {F{1'b0}}};
  assign wb_data   = rsat(pf2_r + x2_scaled);
  assign y_nxt     = byp2_r ? x2_r : rsat(pm2_r + px2_r);

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      x1_r      <= x_in;
      byp1_r    <= ctl.bypass;
      fwd_sel_r <= ctl.fwd;
      if (ctl.fwd) begin
        fwd_data_r <= wb_data;
      end
    end
    if (ctl.s1_go) begin
      pf2_r  <= pf_nxt;
      pm2_r  <= pm_nxt;
      px2_r  <= px_nxt;
      x2_r   <= x1_r;
      byp2_r <= byp1_r;
    end
    if (ctl.s2_go) begin
      y_r <= y_nxt;
    end
  end

  assign y_data = y_r;

endmodule
`default_nettype wire

>>> src/feedback_delay_line_top.sv
// Feedback delay echo: usage
// Input channel in_valid/in_stall/in_sample_in takes one signed sample per item;
// output channel out_valid/out_stall/out_sample_out gives one mixed sample per item.
// Registers via APB-style port: 0x0 length, 0x4 delay, 0x8 feedback, 0xC mix;
// write them only while no item is in flight. Writing the length resets the
// write pointer. Length 0 passes samples straight through.
// An accepted item passes stage regs v1, v2 and the output register to out_valid.
// Throughput: one item per cycle while not stalled; the input also stalls when
// the slot read is the one the immediately preceding item writes (delay 1 or
// length 1), a wait set by the read-multiply-write loop through the delay memory
// and the multiply stage. Reset: registers and pointer clear, then the memory
// clears one entry per cycle, all DEPTH entries (4096 by default), with in_stall
// high; the register port works throughout.
// Receiver stall: the output register holds its item; the two stages behind
// it keep filling, and in_stall rises once they are full.
`default_nettype none
`include "feedback_delay_line_top_macros.svh"
module feedback_delay_line_top
  import fdl_pkg::*;
#(
  parameter int DEPTH          = 4096,
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [CFG_ADDR_W-1:0]         paddr,
  input  wire logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]              prdata,
  output logic                               pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);
  localparam int GW = GAIN_FRAC_BITS + 1;

  logic [LW-1:0] len, dly, dlyc, wp_inc;
  logic [GW-1:0] fb_gain, mix_gain;
  logic          len_wr;

  logic [AW-1:0] wp_r, wp_nxt, wp_eff, rd_addr;
  logic [LW:0]   diff, rd_full;
  logic          bypass;

  logic          v1_r, v1_nxt, w1_r, v2_r, v2_nxt, w2_r, out_valid_r, out_valid_nxt;
  logic [AW-1:0] wp1_r, wp2_r;
  logic          o_en, en2, en1, s1_go, s2_go;
  logic          hit1, hit2, hazard, acc, fwd;

  logic                          mem_busy, rd_en, wr_en;
  logic signed [SAMPLE_BITS-1:0] rd_data, wb_data, y_data;
  fdl_stage_ctl_t                ctl;

  fdl_regs #(
    .DEPTH          (DEPTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .len      (len),
    .dly      (dly),
    .fb_gain  (fb_gain),
    .mix_gain (mix_gain),
    .len_wr   (len_wr)
  );

  assign pready = 1'b1;

  assign bypass  = (len == '0);
  assign wp_eff  = (LW'(wp_r) < len) ? wp_r : '0;
  assign dlyc    = (dly > len) ? len : dly;
  assign diff    = {1'b0, LW'(wp_eff)} - {1'b0, dlyc};
  assign rd_full = diff[LW] ? (diff + {1'b0, len}) : diff;
  assign rd_addr = rd_full[AW-1:0];
  assign wp_inc  = LW'(wp_eff) + LW'(1);

  assign o_en  = !out_valid_r || !out_stall;
  assign s2_go = v2_r && o_en;
  assign en2   = !v2_r || o_en;
  assign s1_go = v1_r && en2;
  assign en1   = !v1_r || en2;

  assign hit1     = v1_r && w1_r && (wp1_r == rd_addr);
  assign hit2     = v2_r && w2_r && (wp2_r == rd_addr);
  assign hazard   = !bypass && (hit1 || (hit2 && !s2_go));
  assign in_stall = mem_busy || !en1 || hazard;
  assign acc      = in_valid && !in_stall;
  assign fwd      = !bypass && hit2;

  always_comb begin
    wp_nxt = wp_r;
    if (len_wr) begin
      wp_nxt = '0;
    end else if (acc && !bypass) begin
      wp_nxt = (wp_inc == len) ? '0 : wp_inc[AW-1:0];
    end
  end

  always_comb begin
    v1_nxt        = acc ? 1'b1 : (s1_go ? 1'b0 : v1_r);
    v2_nxt        = s1_go ? 1'b1 : (s2_go ? 1'b0 : v2_r);
    out_valid_nxt = o_en ? v2_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      w1_r  <= !bypass;
      wp1_r <= wp_eff;
    end
    if (s1_go) begin
      w2_r  <= w1_r;
      wp2_r <= wp1_r;
    end
  end

  assign rd_en = acc && !bypass;
  assign wr_en = s2_go && w2_r;

  fdl_mem #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wp2_r),
    .wr_data (wb_data),
    .busy    (mem_busy)
  );

  assign ctl.acc    = acc;
  assign ctl.bypass = bypass;
  assign ctl.fwd    = fwd;
  assign ctl.s1_go  = s1_go;
  assign ctl.s2_go  = s2_go;

  fdl_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .ctl      (ctl),
    .fb_gain  (fb_gain),
    .mix_gain (mix_gain),
    .x_in     (in_sample_in),
    .rd_data  (rd_data),
    .wb_data  (wb_data),
    .y_data   (y_data)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = y_data;

  `FDL_ASSERT_IMP(a_rw_same_slot_fwd, rd_en && wr_en && (rd_addr == wp2_r), fwd, "read of slot under write not forwarded")
  `FDL_ASSERT_IMP(a_no_wr_while_clr, wr_en, !mem_busy, "item write during memory clear")
  `FDL_ASSERT_IMP(a_wp_in_range, len != '0, LW'(wp_r) < len, "write pointer beyond active length")
  `FDL_ASSERT_NXT(a_len_wr_rewinds, len_wr, wp_r == '0, "length write did not rewind pointer")

endmodule
`default_nettype wire
